@@ rtl/core/gb3_pkg.sv @@
// Shared types, constants and helpers for the 3x3 Gaussian blur block.
package gb3_pkg;

    localparam int MAX_ROW_LENGTH_DEF = 4096;
    localparam int ROW_COUNT_LIMIT    = 4096;
    localparam int ROW_W              = $clog2(ROW_COUNT_LIMIT);
    localparam int CFG_DATA_W         = 13;
    localparam int PIX_W              = 8;
    localparam int SUM_W              = PIX_W + 4;
    localparam int RESET_ROW_LENGTH   = 640;
    localparam int RESET_ROW_COUNT    = 480;

    typedef enum logic {
        CFG_ROW_LENGTH = 1'b0,
        CFG_ROW_COUNT  = 1'b1
    } t_cfg_index;

    // Control word that travels with an accepted transaction into the window stage.
    typedef struct packed {
        logic write;       // pixel of the plane: shift the window and update the lines
        logic emit;        // the transaction releases a result
        logic blur;        // the result is the weighted sum rather than a copy
        logic tail;        // tail of the plane: the result comes from a line buffer
        logic tail_upper;  // tail result comes from the upper line
        logic last;        // final pixel of the plane
    } t_item_ctl;

    // Saturates a row_count write and returns the index of the last row.
    function automatic logic [ROW_W-1:0] last_row_of(input logic [CFG_DATA_W-1:0] value);
        logic [ROW_W-1:0] result;
        if (value == '0) begin
            result = '0;
        end else if (32'(value) > ROW_COUNT_LIMIT) begin
            result = ROW_W'(ROW_COUNT_LIMIT - 1);
        end else begin
            result = ROW_W'(value - CFG_DATA_W'(1));
        end
        return result;
    endfunction

endpackage

@@ rtl/core/gb3_if.sv @@
// Stream and configuration interfaces of the 3x3 Gaussian blur block.
interface gb3_pix_in_if;
    logic                       valid;
    logic                       ready;
    logic [gb3_pkg::PIX_W-1:0]  pixel_in;
    logic                       drain;

    modport source (output valid, output pixel_in, output drain, input ready);
    modport sink   (input valid, input pixel_in, input drain, output ready);
endinterface

interface gb3_pix_out_if;
    logic                       valid;
    logic                       ready;
    logic [gb3_pkg::PIX_W-1:0]  pixel_out;
    logic                       frame_last;

    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

interface gb3_cfg_if;
    logic                            valid;
    logic                            ready;
    gb3_pkg::t_cfg_index             index;
    logic [gb3_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/gb3_seq.sv @@
// Raster sequencer: configuration registers, row and column counters, tail control.
module gb3_seq #(
    parameter int MAX_ROW_LENGTH = gb3_pkg::MAX_ROW_LENGTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  gb3_pkg::t_cfg_index               i_cfg_index,
    input  logic [gb3_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_accept,
    input  logic                              i_drain,
    output gb3_pkg::t_item_ctl                o_ctl,
    output logic [$clog2(MAX_ROW_LENGTH)-1:0] o_rd_addr
);

    localparam int AW      = $clog2(MAX_ROW_LENGTH);
    localparam int RST_LEN = (gb3_pkg::RESET_ROW_LENGTH > MAX_ROW_LENGTH) ?
                             MAX_ROW_LENGTH : gb3_pkg::RESET_ROW_LENGTH;
    localparam logic [AW-1:0] LAST_COL_RST = AW'(RST_LEN - 1);
    localparam logic [gb3_pkg::ROW_W-1:0] LAST_ROW_RST =
        gb3_pkg::ROW_W'(gb3_pkg::RESET_ROW_COUNT - 1);

    function automatic logic [AW-1:0] last_col_of(
        input logic [gb3_pkg::CFG_DATA_W-1:0] value
    );
        logic [AW-1:0] result;
        if (value == '0) begin
            result = '0;
        end else if (32'(value) > MAX_ROW_LENGTH) begin
            result = AW'(MAX_ROW_LENGTH - 1);
        end else begin
            result = AW'(32'(value) - 32'd1);
        end
        return result;
    endfunction

    logic [AW-1:0]             r_last_col, n_last_col;
    logic [gb3_pkg::ROW_W-1:0] r_last_row, n_last_row;
    logic [AW-1:0]             r_col, n_col;
    logic [gb3_pkg::ROW_W-1:0] r_row, n_row;
    logic                      r_tail, n_tail;
    logic                      r_tail_upper, n_tail_upper;
    logic                      at_row_end;

    always_comb begin
        n_last_col   = r_last_col;
        n_last_row   = r_last_row;
        n_col        = r_col;
        n_row        = r_row;
        n_tail       = r_tail;
        n_tail_upper = r_tail_upper;
        o_ctl        = '0;
        o_rd_addr    = r_col;
        at_row_end   = (r_col == r_last_col);

        if (r_tail) begin
            o_ctl.tail       = 1'b1;
            o_ctl.emit       = 1'b1;
            o_ctl.tail_upper = r_tail_upper;
            o_ctl.last       = !r_tail_upper && at_row_end;
            if (r_tail_upper) begin
                o_rd_addr = r_last_col;
            end
        end else if (!i_drain) begin
            o_ctl.write = 1'b1;
            // The first result leaves with the second pixel of the second row.
            o_ctl.emit  = (r_row > gb3_pkg::ROW_W'(1)) ||
                          ((r_row == gb3_pkg::ROW_W'(1)) && (r_col != '0));
            o_ctl.blur  = (r_row > gb3_pkg::ROW_W'(1)) && (r_col > AW'(1));
        end

        if (i_accept) begin
            if (r_tail) begin
                if (r_tail_upper) begin
                    n_tail_upper = 1'b0;
                end else if (at_row_end) begin
                    n_tail = 1'b0;
                    n_col  = '0;
                end else begin
                    n_col = r_col + AW'(1);
                end
            end else if (!i_drain) begin
                if (at_row_end) begin
                    n_col = '0;
                    if (r_row == r_last_row) begin
                        n_tail       = 1'b1;
                        n_tail_upper = (r_last_row != '0);
                        n_row        = '0;
                    end else begin
                        n_row = r_row + gb3_pkg::ROW_W'(1);
                    end
                end else begin
                    n_col = r_col + AW'(1);
                end
            end
        end

        if (i_cfg_we) begin
            n_col        = '0;
            n_row        = '0;
            n_tail       = 1'b0;
            n_tail_upper = 1'b0;
            case (i_cfg_index)
                gb3_pkg::CFG_ROW_LENGTH: n_last_col = last_col_of(i_cfg_data);
                gb3_pkg::CFG_ROW_COUNT:  n_last_row = gb3_pkg::last_row_of(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col   <= LAST_COL_RST;
            r_last_row   <= LAST_ROW_RST;
            r_col        <= '0;
            r_row        <= '0;
            r_tail       <= 1'b0;
            r_tail_upper <= 1'b0;
        end else begin
            r_last_col   <= n_last_col;
            r_last_row   <= n_last_row;
            r_col        <= n_col;
            r_row        <= n_row;
            r_tail       <= n_tail;
            r_tail_upper <= n_tail_upper;
        end
    end

endmodule

@@ rtl/core/gb3_line_buf.sv @@
// Upper and middle line memories with registered read and write-to-read forwarding.
module gb3_line_buf #(
    parameter int MAX_ROW_LENGTH = gb3_pkg::MAX_ROW_LENGTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_re,
    input  logic [$clog2(MAX_ROW_LENGTH)-1:0] i_ra,
    output logic [gb3_pkg::PIX_W-1:0]         o_q_up,
    output logic [gb3_pkg::PIX_W-1:0]         o_q_mid,
    input  logic                              i_we,
    input  logic [$clog2(MAX_ROW_LENGTH)-1:0] i_wa,
    input  logic [gb3_pkg::PIX_W-1:0]         i_wd_up,
    input  logic [gb3_pkg::PIX_W-1:0]         i_wd_mid
);

    logic [gb3_pkg::PIX_W-1:0] mem_up  [MAX_ROW_LENGTH];
    logic [gb3_pkg::PIX_W-1:0] mem_mid [MAX_ROW_LENGTH];
    logic [gb3_pkg::PIX_W-1:0] r_q_up, r_q_mid;
    logic [gb3_pkg::PIX_W-1:0] r_fwd_up, r_fwd_mid;
    logic                      r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem_up[i_wa]  <= i_wd_up;
            mem_mid[i_wa] <= i_wd_mid;
        end
        if (i_re) begin
            r_q_up    <= mem_up[i_ra];
            r_q_mid   <= mem_mid[i_ra];
            r_fwd_up  <= i_wd_up;
            r_fwd_mid <= i_wd_mid;
        end
    end

    // A read that meets a write to the same entry at one edge takes the new data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_re) begin
            r_fwd <= i_we && (i_wa == i_ra);
        end
    end

    assign o_q_up  = r_fwd ? r_fwd_up  : r_q_up;
    assign o_q_mid = r_fwd ? r_fwd_mid : r_q_mid;

endmodule

@@ rtl/core/gb3_window.sv @@
// Window stage: 3x3 taps, weighted sum, line write-back and the output register.
module gb3_window #(
    parameter int MAX_ROW_LENGTH = gb3_pkg::MAX_ROW_LENGTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  gb3_pkg::t_item_ctl                i_ctl,
    input  logic [gb3_pkg::PIX_W-1:0]         i_pix,
    input  logic [$clog2(MAX_ROW_LENGTH)-1:0] i_addr,
    input  logic [gb3_pkg::PIX_W-1:0]         i_q_up,
    input  logic [gb3_pkg::PIX_W-1:0]         i_q_mid,
    input  logic                              i_out_ready,
    output logic                              o_free,
    output logic                              o_we,
    output logic [$clog2(MAX_ROW_LENGTH)-1:0] o_wa,
    output logic [gb3_pkg::PIX_W-1:0]         o_wd_up,
    output logic [gb3_pkg::PIX_W-1:0]         o_wd_mid,
    output logic                              o_out_valid,
    output logic [gb3_pkg::PIX_W-1:0]         o_pixel_out,
    output logic                              o_frame_last
);

    localparam int AW = $clog2(MAX_ROW_LENGTH);
    localparam int SW = gb3_pkg::SUM_W;

    logic                      r_s1_valid;
    gb3_pkg::t_item_ctl        r_s1_ctl;
    logic [gb3_pkg::PIX_W-1:0] r_s1_pix;
    logic [AW-1:0]             r_s1_addr;
    logic [gb3_pkg::PIX_W-1:0] r_tap [9];
    logic [gb3_pkg::PIX_W-1:0] n_tap [9];
    logic                      r_out_valid;
    logic [gb3_pkg::PIX_W-1:0] r_out_pix;
    logic                      r_out_last;
    logic                      out_free;
    logic                      s1_adv;
    logic [SW-1:0]             sum;
    logic [gb3_pkg::PIX_W-1:0] value;

    assign out_free = !r_out_valid || i_out_ready;
    assign s1_adv   = r_s1_valid && (!r_s1_ctl.emit || out_free);
    assign o_free   = !r_s1_valid || s1_adv;

    always_comb begin
        n_tap[0] = r_tap[1];
        n_tap[1] = r_tap[2];
        n_tap[2] = i_q_up;
        n_tap[3] = r_tap[4];
        n_tap[4] = r_tap[5];
        n_tap[5] = i_q_mid;
        n_tap[6] = r_tap[7];
        n_tap[7] = r_tap[8];
        n_tap[8] = r_s1_pix;

        // Kernel 1-2-1 by 1-2-1 with the rounding constant folded in.
        sum = SW'(n_tap[0]) + (SW'(n_tap[1]) << 1) + SW'(n_tap[2])
            + (SW'(n_tap[3]) << 1) + (SW'(n_tap[4]) << 2) + (SW'(n_tap[5]) << 1)
            + SW'(n_tap[6]) + (SW'(n_tap[7]) << 1) + SW'(n_tap[8]) + SW'(8);

        if (r_s1_ctl.blur) begin
            value = sum[SW-1:4];
        end else if (r_s1_ctl.tail) begin
            value = r_s1_ctl.tail_upper ? i_q_up : i_q_mid;
        end else begin
            // The window center after the shift, which is the old middle-right tap.
            value = r_tap[5];
        end
    end

    assign o_we     = s1_adv && r_s1_ctl.write;
    assign o_wa     = r_s1_addr;
    assign o_wd_up  = i_q_mid;
    assign o_wd_mid = r_s1_pix;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1_ctl  <= i_ctl;
            r_s1_pix  <= i_pix;
            r_s1_addr <= i_addr;
        end
        if (s1_adv && r_s1_ctl.emit) begin
            r_out_pix  <= value;
            r_out_last <= r_s1_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 9; k++) begin
                r_tap[k] <= '0;
            end
        end else begin
            if (o_we) begin
                for (int k = 0; k < 9; k++) begin
                    r_tap[k] <= n_tap[k];
                end
            end
            if (i_load) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv && r_s1_ctl.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_out  = r_out_pix;
    assign o_frame_last = r_out_last;

endmodule

@@ rtl/core/gaussian_blur_3x3.sv @@
// Results: a result passes the window stage register and then the output register; results
// trail the pixel stream by row_length+1 transactions, and drain transactions flush the tail.
// Throughput: one transaction per cycle unless the output stalls, set by the single read and
// write port of each line memory, used once per pixel in a read-modify-write over two stages.
// Reset: synchronous, active low; clears counters, valid flags and the window taps and sets
// row_length to 640 and row_count to 480. The line memories are not cleared and need no
// clearing pass.
module gaussian_blur_3x3 #(
    parameter int MAX_ROW_LENGTH = gb3_pkg::MAX_ROW_LENGTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gb3_pix_in_if.sink    i_pix,
    gb3_pix_out_if.source o_pix,
    gb3_cfg_if.sink       i_cfg
);

    localparam int AW = $clog2(MAX_ROW_LENGTH);

    // The pipeline has two stages. At the accept edge the sequencer classifies the
    // transaction from its counters and both line memories are read at the column.
    // In the window stage the memory data enters the 3x3 window, the blurred or copied
    // pixel goes to the output register and the column is written back: the upper line
    // takes the old middle value and the middle line takes the new pixel.
    gb3_pkg::t_item_ctl        item_ctl;
    logic [AW-1:0]             rd_addr;
    logic                      accept;
    logic                      stage_free;
    logic                      mem_we;
    logic [AW-1:0]             mem_wa;
    logic [gb3_pkg::PIX_W-1:0] mem_wd_up, mem_wd_mid;
    logic [gb3_pkg::PIX_W-1:0] mem_q_up, mem_q_mid;
    logic                      cfg_we;

    // The configuration channel always takes a transaction; the user must make writes only while
    // the block is idle, which the block does not enforce, and each write restarts the plane.
    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid;

    // A new pixel is taken whenever the window stage is empty or moves on in this cycle,
    // so a held output register blocks the input only while the window stage waits to emit.
    assign i_pix.ready = stage_free;
    assign accept      = i_pix.valid && stage_free;

    gb3_seq #(
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_accept    (accept),
        .i_drain     (i_pix.drain),
        .o_ctl       (item_ctl),
        .o_rd_addr   (rd_addr)
    );

    // Consecutive pixels can hit the same column when a row is one pixel long; the
    // memory wrapper forwards the write of the older pixel to the younger one's read.
    gb3_line_buf #(
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
    ) u_line_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_re     (accept),
        .i_ra     (rd_addr),
        .o_q_up   (mem_q_up),
        .o_q_mid  (mem_q_mid),
        .i_we     (mem_we),
        .i_wa     (mem_wa),
        .i_wd_up  (mem_wd_up),
        .i_wd_mid (mem_wd_mid)
    );

    gb3_window #(
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
    ) u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (accept),
        .i_ctl        (item_ctl),
        .i_pix        (i_pix.pixel_in),
        .i_addr       (rd_addr),
        .i_q_up       (mem_q_up),
        .i_q_mid      (mem_q_mid),
        .i_out_ready  (o_pix.ready),
        .o_free       (stage_free),
        .o_we         (mem_we),
        .o_wa         (mem_wa),
        .o_wd_up      (mem_wd_up),
        .o_wd_mid     (mem_wd_mid),
        .o_out_valid  (o_pix.valid),
        .o_pixel_out  (o_pix.pixel_out),
        .o_frame_last (o_pix.frame_last)
    );

endmodule

@@ rtl/core/gb3_chk.sv @@
// Port-level checker for the 3x3 Gaussian blur block, bound to its top level.
module gb3_chk (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [gb3_pkg::PIX_W-1:0] i_out_pixel,
    input logic                      i_out_last
);

    // A stalled result keeps its payload until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_pixel) && $stable(i_out_last))
        else $error("stalled result changed or dropped");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown after reset");

    // A result on an empty output follows an accepted input through the window stage.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result without a releasing transaction");

endmodule

bind gaussian_blur_3x3 gb3_chk u_gb3_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_pixel (o_pix.pixel_out),
    .i_out_last  (o_pix.frame_last)
);

@@ tb/sv/gb3_blur_checker.sv @@
// Checker for the 3x3 Gaussian blur block: predicts every output pixel and compares it.
`timescale 1ns / 100ps
module gb3_blur_checker
    import gb3_pkg::*;
#(
    parameter int MAX_ROW_LENGTH = MAX_ROW_LENGTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    gb3_pix_in_if  i_pix,
    gb3_pix_out_if i_res,
    gb3_cfg_if     i_cfg,
    output int     o_fail_count,
    output int     o_pending
);

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } t_out_pixel;

    logic [CFG_DATA_W-1:0] row_length_reg;
    logic [CFG_DATA_W-1:0] row_count_reg;
    logic [PIX_W-1:0]      upper_row  [MAX_ROW_LENGTH];
    logic [PIX_W-1:0]      middle_row [MAX_ROW_LENGTH];
    logic [PIX_W-1:0]      taps       [9];
    int unsigned           in_col;
    int unsigned           in_row;
    int unsigned           out_pos;
    t_out_pixel            pixels_due [$];
    int                    fail_total = 0;
    int                    result_count = 0;

    // The line memories hold zero until written; no visible result depends on that.
    initial begin
        for (int i = 0; i < MAX_ROW_LENGTH; i++) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
    end

    function automatic int unsigned plane_width();
        if (row_length_reg == '0) return 1;
        if (int'(row_length_reg) > MAX_ROW_LENGTH) return MAX_ROW_LENGTH;
        return 32'(row_length_reg);
    endfunction

    function automatic int unsigned plane_height();
        if (row_count_reg == '0) return 1;
        if (int'(row_count_reg) > ROW_COUNT_LIMIT) return ROW_COUNT_LIMIT;
        return 32'(row_count_reg);
    endfunction

    task automatic note_fail(input string msg);
        fail_total++;
        if (fail_total <= 10) $display("%s", msg);
    endtask

    task automatic blur_step(input logic [PIX_W-1:0] pix, input logic is_drain);
        int unsigned w, h, c, r, n, q, total, orow, ocol, sum, k;
        logic [PIX_W-1:0] value;
        logic border;
        t_out_pixel due;
        w = plane_width();
        h = plane_height();
        if (in_row < h) begin
            if (is_drain) return;
            c = (in_col >= w) ? w - 1 : in_col;
            r = in_row;
            n = r * w + c;
            // A new row releases the last column of two rows up, kept in the middle tap.
            value = (c == 0) ? taps[5] : '0;
            for (k = 0; k < 3; k++) begin
                taps[3*k]   = taps[3*k+1];
                taps[3*k+1] = taps[3*k+2];
            end
            taps[2] = upper_row[c];
            taps[5] = middle_row[c];
            taps[8] = pix;
            upper_row[c]  = middle_row[c];
            middle_row[c] = pix;
            if (c >= 1) begin
                orow = r - 1;
                ocol = c - 1;
                border = (r == 0) || (orow == 0) || (orow == h - 1)
                      || (ocol == 0) || (ocol == w - 1);
                sum = 32'(taps[0]) + 2 * 32'(taps[1]) + 32'(taps[2])
                    + 2 * 32'(taps[3]) + 4 * 32'(taps[4]) + 2 * 32'(taps[5])
                    + 32'(taps[6]) + 2 * 32'(taps[7]) + 32'(taps[8]);
                value = border ? taps[4] : PIX_W'((sum + 8) >> 4);
            end
            if (c + 1 >= w) begin
                in_col = 0;
                in_row = r + 1;
            end else begin
                in_col = c + 1;
            end
            if (n >= w + 1) begin
                due.pixel = value;
                due.last  = 1'b0;
                pixels_due.push_back(due);
                out_pos++;
            end
        end else begin
            // Tail of the plane: every transaction pushes out one pixel from the line memories.
            total = w * h;
            q = (out_pos >= total) ? total - 1 : out_pos;
            orow = q / w;
            ocol = q % w;
            due.pixel = (orow == h - 1) ? middle_row[ocol] : upper_row[ocol];
            due.last  = (q == total - 1);
            pixels_due.push_back(due);
            if (due.last) begin
                in_col  = 0;
                in_row  = 0;
                out_pos = 0;
            end else begin
                out_pos = q + 1;
            end
        end
    endtask

    task automatic check_pixel(input logic [PIX_W-1:0] got_pixel, input logic got_last);
        t_out_pixel due;
        if (pixels_due.size() == 0) begin
            note_fail($sformatf("unexpected output: pixel_out %0d frame_last %0d",
                                got_pixel, got_last));
            return;
        end
        due = pixels_due.pop_front();
        if (got_pixel !== due.pixel) begin
            note_fail($sformatf("output %0d: pixel_out expected %0d, got %0d",
                                result_count, due.pixel, got_pixel));
        end
        if (got_last !== due.last) begin
            note_fail($sformatf("output %0d: frame_last expected %0d, got %0d",
                                result_count, due.last, got_last));
        end
        result_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            row_length_reg = CFG_DATA_W'(RESET_ROW_LENGTH);
            row_count_reg  = CFG_DATA_W'(RESET_ROW_COUNT);
            for (int i = 0; i < 9; i++) taps[i] = '0;
            in_col  = 0;
            in_row  = 0;
            out_pos = 0;
            pixels_due.delete();
        end else begin
            // A register write restarts the plane but keeps taps and line memories.
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == CFG_ROW_LENGTH) begin
                    row_length_reg = i_cfg.data;
                end else begin
                    row_count_reg = i_cfg.data;
                end
                in_col  = 0;
                in_row  = 0;
                out_pos = 0;
            end
            if (i_pix.valid && i_pix.ready) blur_step(i_pix.pixel_in, i_pix.drain);
            if (i_res.valid && i_res.ready) check_pixel(i_res.pixel_out, i_res.frame_last);
        end
        o_pending    <= pixels_due.size();
        o_fail_count <= fail_total;
    end

endmodule

@@ tb/sv/gaussian_blur_3x3_tb.sv @@
// Top of the blur testbench: drives pixel and register traffic and reports the verdict.
`timescale 1ns / 100ps
module gaussian_blur_3x3_tb;
    import gb3_pkg::*;

    localparam int LINE_DEPTH     = MAX_ROW_LENGTH_DEF;
    localparam int RANDOM_ITEMS   = 400;
    // The block registers each result in the window stage and then the output register; a drain that
    // releases nothing may still be in flight, so register writes wait a little longer.
    localparam int QUIET_CYCLES   = 6;
    // Longest idle stretch in a correct run is a sender gap overlapping a sink stall.
    localparam int WATCHDOG_LIMIT = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    gb3_pix_in_if  pix_ch();
    gb3_pix_out_if res_ch();
    gb3_cfg_if     cfg_ch();

    int          fail_count;
    int          pending_results;
    // Plane geometry as the block sees it, used only to shape the stimulus.
    int unsigned plane_w = RESET_ROW_LENGTH;
    int unsigned plane_h = RESET_ROW_COUNT;
    int unsigned sent_items;
    int unsigned noise_pct = 0;
    int unsigned tail_pixel_pct = 0;
    int unsigned hold_left = 0;
    int unsigned idle_cycles = 0;
    // When set, neither side inserts gaps or stalls.
    logic        calm = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    gaussian_blur_3x3 #(
        .MAX_ROW_LENGTH(LINE_DEPTH)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix_ch),
        .o_pix  (res_ch),
        .i_cfg  (cfg_ch)
    );

    gb3_blur_checker #(
        .MAX_ROW_LENGTH(LINE_DEPTH)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (pix_ch),
        .i_res       (res_ch),
        .i_cfg       (cfg_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending_results)
    );

    // Gap length in cycles: mostly none, sometimes a few, rarely a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Pixel values lean toward the extremes so the rounding and the top of the range get hit.
    function automatic logic [PIX_W-1:0] rand_pixel();
        if ($urandom_range(0, 99) < 15) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    function automatic int unsigned clamp_dim(input logic [CFG_DATA_W-1:0] value,
                                              input int unsigned limit);
        if (value == '0) return 1;
        if (32'(value) > limit) return limit;
        return 32'(value);
    endfunction

    // Pixels of the plane plus the drain transactions that flush its tail.
    function automatic int unsigned plane_span();
        int unsigned npix;
        npix = plane_w * plane_h;
        return npix + ((npix < plane_w + 1) ? npix : plane_w + 1);
    endfunction

    // Result side: random back-pressure, one nonblocking write of ready per edge.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            res_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!calm && $urandom_range(0, 99) < 20) begin
            res_ch.ready <= 1'b0;
            hold_left <= pick_gap();
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // Watchdog: counts cycles in which no channel completes a transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offers one pixel transaction and returns at the edge that accepts it. With no gap,
    // valid stays high and only the payload changes.
    task automatic send_item(input logic [PIX_W-1:0] value, input logic is_drain);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_ch.valid    <= 1'b1;
        pix_ch.pixel_in <= value;
        pix_ch.drain    <= is_drain;
        @(posedge i_clk);
        while (!pix_ch.ready) @(posedge i_clk);
    endtask

    // Holds the sender until every predicted pixel has come out, then lets
    // any drain still in flight settle. The first edge makes the pending count current.
    task automatic await_drained();
        pix_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // Register writes only happen with the block idle.
    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] value);
        await_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_ROW_LENGTH) begin
            plane_w = clamp_dim(value, LINE_DEPTH);
        end else begin
            plane_h = clamp_dim(value, ROW_COUNT_LIMIT);
        end
    endtask

    // Sends one plane in raster order followed by its tail flush, stopping early after
    // stop_at transactions. Stray drains inside the plane are ignored by the block, and
    // a pixel offered during the tail acts as a drain.
    task automatic run_plane(input int unsigned stop_at);
        int unsigned npix, span, k;
        npix = plane_w * plane_h;
        span = plane_span();
        for (k = 0; k < span && k < stop_at; k++) begin
            if (k < npix) begin
                if ($urandom_range(0, 99) < noise_pct) send_item(rand_pixel(), 1'b1);
                send_item(rand_pixel(), 1'b0);
            end else begin
                send_item(rand_pixel(), $urandom_range(0, 99) >= tail_pixel_pct);
            end
            sent_items++;
            // Now and then the sender waits for the result side to catch up completely.
            if ($urandom_range(0, 299) == 0) await_drained();
        end
    endtask

    initial begin
        int unsigned k, stop_at;
        logic wide, must_restart;

        pix_ch.valid    <= 1'b0;
        pix_ch.pixel_in <= '0;
        pix_ch.drain    <= 1'b0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= CFG_ROW_LENGTH;
        cfg_ch.data     <= '0;
        i_rst_n         <= 1'b0;
        sent_items = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset geometry is 640 x 480. A few pixels of the first row go in, none of them
        // leaves this early, and the write that follows abandons the plane.
        noise_pct = 5;
        run_plane(30);

        // Directed part on a 3 x 3 plane, the smallest with an interior pixel.
        noise_pct = 0;
        tail_pixel_pct = 0;
        write_reg(CFG_ROW_LENGTH, 13'd3);
        write_reg(CFG_ROW_COUNT, 13'd3);
        // Restart mid-plane: two pixels, then a write sends the block back to the origin.
        send_item(8'd17, 1'b0);
        send_item(8'd200, 1'b0);
        write_reg(CFG_ROW_COUNT, 13'd3);
        // Checkerboard of 0 and 255; the center becomes (4*255 + 4*255 + 8) >> 4 = 128.
        // A drain in the middle of the plane must be ignored.
        for (k = 0; k < 9; k++) begin
            if (k == 4) send_item(8'hA5, 1'b1);
            send_item((k % 2 == 0) ? 8'hFF : 8'h00, 1'b0);
        end
        // Tail: a real pixel here is dropped and acts as a drain, then plain drains.
        send_item(8'h5A, 1'b0);
        repeat (3) send_item(8'h00, 1'b1);
        // Zero in both registers acts as a 1 x 1 plane: the pixel comes back marked last.
        write_reg(CFG_ROW_LENGTH, 13'd0);
        write_reg(CFG_ROW_COUNT, 13'd0);
        send_item(8'h80, 1'b0);
        send_item(8'h7F, 1'b1);

        // Random planes of small size. Most run through in full, some are cut short and
        // restarted, and some follow the previous plane with no write in between.
        sent_items = 0;
        must_restart = 1'b0;
        while (sent_items < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 3) == 0);
            noise_pct = $urandom_range(0, 15);
            tail_pixel_pct = $urandom_range(0, 40);
            wide = ($urandom_range(0, 9) == 0);
            if (must_restart || $urandom_range(0, 3) != 0) begin
                write_reg(CFG_ROW_LENGTH, wide ? CFG_DATA_W'($urandom_range(13, 40))
                                               : CFG_DATA_W'($urandom_range(0, 12)));
            end
            if (wide || $urandom_range(0, 3) != 0) begin
                write_reg(CFG_ROW_COUNT, wide ? CFG_DATA_W'($urandom_range(0, 3))
                                              : CFG_DATA_W'($urandom_range(0, 8)));
            end
            must_restart = ($urandom_range(0, 9) == 0);
            stop_at = must_restart ? $urandom_range(1, plane_span() - 1) : plane_span();
            run_plane(stop_at);
        end

        // Extremes of the geometry. Only the opening of each large plane is sent, and the
        // next write abandons it.
        calm = 1'b0;
        noise_pct = 1;
        tail_pixel_pct = 10;
        // Widest line: an over-range value saturates to the full line memory depth.
        write_reg(CFG_ROW_LENGTH, 13'h1FFF);
        write_reg(CFG_ROW_COUNT, 13'd2);
        run_plane(20);
        // Tallest plane, one column wide; the row count saturates as well and the
        // column passes through unchanged.
        write_reg(CFG_ROW_LENGTH, 13'd1);
        write_reg(CFG_ROW_COUNT, 13'h1FFF);
        run_plane(20);
        // Exact maxima in both registers.
        write_reg(CFG_ROW_LENGTH, 13'd4096);
        write_reg(CFG_ROW_COUNT, 13'd4096);
        run_plane(20);
        // A last small plane sent through in full.
        write_reg(CFG_ROW_LENGTH, 13'd5);
        write_reg(CFG_ROW_COUNT, 13'd4);
        run_plane(plane_span());

        await_drained();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ gaussian_blur_3x3.f @@
rtl/core/gb3_pkg.sv
rtl/core/gb3_if.sv
rtl/core/gb3_seq.sv
rtl/core/gb3_line_buf.sv
rtl/core/gb3_window.sv
rtl/core/gaussian_blur_3x3.sv
rtl/core/gb3_chk.sv
tb/sv/gb3_blur_checker.sv
tb/sv/gaussian_blur_3x3_tb.sv
